// ===== rtl/core/icc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icc_pkg
// Shared types and constants of the identifier case converter.
// ----------------------------------------------------------------------------
package icc_pkg;

  typedef enum logic [2:0] {
    STYLE_ORIG   = 3'd0,
    STYLE_SNAKE  = 3'd1,
    STYLE_KEBAB  = 3'd2,
    STYLE_CAMEL  = 3'd3,
    STYLE_PASCAL = 3'd4,
    STYLE_TITLE  = 3'd5
  } style_t;

  localparam logic [7:0] REG_STYLE     = 8'd0;
  localparam logic [7:0] REG_MAX_CHARS = 8'd1;

  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CASE_DIFF = 8'h20;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] char_out;
    logic       has_char;
    logic       name_done;
  } res_t;

  // results of one item: count (0..2) and up to two results in order
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } step_t;

endpackage
`default_nettype wire

// ===== rtl/core/icc_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icc_core
// Configuration registers, per-name state and the per-byte conversion logic.
// ----------------------------------------------------------------------------
module icc_core #(
  parameter int NAME_BYTES = 256
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [7:0]    cfg_index,
  input  wire logic [7:0]    cfg_data,
  input  wire logic          fire,
  input  wire logic [7:0]    char_q,
  input  wire logic          end_q,
  output icc_pkg::step_t     step
);

  localparam int LIMIT_MAX = (NAME_BYTES - 1 < 255) ? NAME_BYTES - 1 : 255;
  localparam int CNT_W = (LIMIT_MAX < 2) ? 1 : $clog2(LIMIT_MAX + 1);
  localparam logic [7:0] LIM8 = 8'(LIMIT_MAX);

  icc_pkg::style_t style;
  logic [7:0]      max_chars;

  logic [CNT_W-1:0] cnt, cnt_next;
  logic joiner_pending, joiner_pending_next;
  logic last_was_upper, last_was_upper_next;
  logic raise_next, raise_next_next;
  logic at_first_char, at_first_char_next;

  logic [7:0] lim;
  logic [7:0] cnt8;
  logic       c_upper, c_lower, c_digit, c_alnum, c_sep;
  logic [7:0] c_to_lower, c_to_upper;
  logic [7:0] joiner;
  logic       jp_eff;
  logic       r_title;
  logic [7:0] ch;

  assign lim  = (max_chars > LIM8) ? LIM8 : max_chars;
  assign cnt8 = 8'(cnt);

  assign c_upper    = (char_q >= 8'h41) && (char_q <= 8'h5A);
  assign c_lower    = (char_q >= 8'h61) && (char_q <= 8'h7A);
  assign c_digit    = (char_q >= 8'h30) && (char_q <= 8'h39);
  assign c_alnum    = c_upper || c_lower || c_digit;
  assign c_sep      = (char_q == icc_pkg::CH_UNDER) || (char_q == icc_pkg::CH_DASH) ||
                      (char_q == icc_pkg::CH_SPACE);
  assign c_to_lower = c_upper ? char_q + icc_pkg::CASE_DIFF : char_q;
  assign c_to_upper = c_lower ? char_q - icc_pkg::CASE_DIFF : char_q;
  assign joiner     = (style == icc_pkg::STYLE_SNAKE) ? icc_pkg::CH_UNDER : icc_pkg::CH_DASH;

  always_ff @(posedge clk) begin
    if (rst) begin
      style     <= icc_pkg::STYLE_SNAKE;
      max_chars <= 8'd255;
    end else if (cfg_we) begin
      if (cfg_index == icc_pkg::REG_STYLE) begin
        style <= icc_pkg::style_t'(cfg_data[2:0]);
      end else if (cfg_index == icc_pkg::REG_MAX_CHARS) begin
        max_chars <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt            <= '0;
      joiner_pending <= 1'b0;
      last_was_upper <= 1'b0;
      raise_next     <= 1'b0;
      at_first_char  <= 1'b1;
    end else if (fire) begin
      cnt            <= cnt_next;
      joiner_pending <= joiner_pending_next;
      last_was_upper <= last_was_upper_next;
      raise_next     <= raise_next_next;
      at_first_char  <= at_first_char_next;
    end
  end

  always_comb begin
    step                = '0;
    cnt_next            = cnt;
    joiner_pending_next = joiner_pending;
    last_was_upper_next = last_was_upper;
    raise_next_next     = raise_next;
    at_first_char_next  = at_first_char;
    jp_eff              = joiner_pending;
    r_title             = raise_next || at_first_char;
    ch                  = char_q;
    if (end_q) begin
      step.n              = 2'd1;
      step.r0.name_done   = 1'b1;
      cnt_next            = '0;
      joiner_pending_next = 1'b0;
      last_was_upper_next = 1'b0;
      raise_next_next     = 1'b0;
      at_first_char_next  = 1'b1;
    end else if ((char_q != 8'd0) && (cnt8 < lim)) begin
      case (style) inside
        icc_pkg::STYLE_SNAKE, icc_pkg::STYLE_KEBAB: begin
          if (c_sep) begin
            if (cnt != '0) begin
              joiner_pending_next = 1'b1;
            end
            last_was_upper_next = 1'b0;
          end else if (c_alnum) begin
            if (c_upper) begin
              if ((cnt != '0) && !last_was_upper) begin
                jp_eff = 1'b1;
              end
              ch                  = c_to_lower;
              last_was_upper_next = 1'b1;
            end else begin
              last_was_upper_next = 1'b0;
            end
            joiner_pending_next = 1'b0;
            if (jp_eff && (({1'b0, cnt8} + 9'd2) <= {1'b0, lim})) begin
              step.n          = 2'd2;
              step.r0         = '{char_out: joiner, has_char: 1'b1, name_done: 1'b0};
              step.r1         = '{char_out: ch, has_char: 1'b1, name_done: 1'b0};
              cnt_next        = cnt + CNT_W'(2);
            end else begin
              step.n          = 2'd1;
              step.r0         = '{char_out: ch, has_char: 1'b1, name_done: 1'b0};
              cnt_next        = cnt + CNT_W'(1);
            end
          end
        end
        icc_pkg::STYLE_CAMEL, icc_pkg::STYLE_PASCAL: begin
          if (c_sep) begin
            raise_next_next = 1'b1;
          end else if (c_alnum) begin
            if (at_first_char) begin
              ch = (style == icc_pkg::STYLE_PASCAL) ? c_to_upper : c_to_lower;
            end else if (raise_next) begin
              ch = c_to_upper;
            end
            step.n             = 2'd1;
            step.r0            = '{char_out: ch, has_char: 1'b1, name_done: 1'b0};
            cnt_next           = cnt + CNT_W'(1);
            raise_next_next    = 1'b0;
            at_first_char_next = 1'b0;
          end
        end
        icc_pkg::STYLE_TITLE: begin
          if (c_sep) begin
            ch      = icc_pkg::CH_SPACE;
            r_title = 1'b1;
          end else if (c_alnum) begin
            ch      = r_title ? c_to_upper : c_to_lower;
            r_title = 1'b0;
          end
          step.n             = 2'd1;
          step.r0            = '{char_out: ch, has_char: 1'b1, name_done: 1'b0};
          cnt_next           = cnt + CNT_W'(1);
          raise_next_next    = r_title;
          at_first_char_next = 1'b0;
        end
        default: begin
          step.n   = 2'd1;
          step.r0  = '{char_out: char_q, has_char: 1'b1, name_done: 1'b0};
          cnt_next = cnt + CNT_W'(1);
        end
      endcase
    end
  end

  a_pair_is_joiner: assert property (@(posedge clk) disable iff (rst)
    (step.n == 2'd2) |-> (((style == icc_pkg::STYLE_SNAKE) || (style == icc_pkg::STYLE_KEBAB))
                         && (step.r0.char_out == joiner)))
    else $error("two results from an item without a joiner");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && end_q) |=> ((cnt == '0) && !joiner_pending && at_first_char))
    else $error("per-name state not cleared at end item");

endmodule
`default_nettype wire

// ===== rtl/core/icc_out_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icc_out_queue
// Result queue: up to two results in per cycle, one out per ready cycle.
// ----------------------------------------------------------------------------
module icc_out_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [1:0]    push_n,
  input  wire icc_pkg::res_t push0,
  input  wire icc_pkg::res_t push1,
  output logic               room,
  output logic               out_valid,
  input  wire logic          out_ready,
  output icc_pkg::res_t      head
);

  localparam int DEPTH = icc_pkg::QUEUE_DEPTH;
  localparam int CW    = $clog2(DEPTH + 1);

  icc_pkg::res_t q [DEPTH];
  icc_pkg::res_t q_next [DEPTH];
  logic [CW-1:0] cnt, cnt_next, base;
  logic          pop;

  assign out_valid = (cnt != '0);
  assign pop       = out_valid && out_ready;
  assign base      = cnt - CW'(pop);
  assign room      = base <= CW'(DEPTH - 2);
  assign cnt_next  = base + CW'(push_n);
  assign head      = q[0];

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      q_next[i] = q[i];
    end
    if (pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        q_next[i] = q[i + 1];
      end
    end
    for (int i = 0; i < DEPTH; i++) begin
      if ((push_n != 2'd0) && (CW'(i) == base)) begin
        q_next[i] = push0;
      end
      if ((push_n == 2'd2) && (CW'(i) == base + CW'(1))) begin
        q_next[i] = push1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("result queue overflow");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    (push_n != 2'd0) |-> (room && (push_n != 2'd3)))
    else $error("push without room");

endmodule
`default_nettype wire

// ===== rtl/core/identifier_case_converter_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// identifier_case_converter_top
// Converts a byte stream of names into snake, kebab, camel, Pascal or title
// case, or passes it through, one byte per item.
// ----------------------------------------------------------------------------
// The block takes one input item per cycle while the queue has room. Each
// item is held in an input register, converted combinationally and written to
// a four-entry result queue. An item gives zero, one or two results (a joiner
// and its letter in snake and kebab case); the output port moves one result
// per cycle while out_ready is high, so two-result items stall the input.
// Input is taken when the input register is empty or the queue has two free
// entries after this cycle's output. Configuration writes complete at once.
// ----------------------------------------------------------------------------
module identifier_case_converter_top #(
  parameter int NAME_BYTES = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] char_in,
  input  wire logic       end_mark,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      char_out,
  output logic            has_char,
  output logic            name_done
);

  logic          in_vld;
  logic [7:0]    char_q;
  logic          end_q;
  logic          room;
  logic          adv;
  logic [1:0]    push_n;
  icc_pkg::step_t step;
  icc_pkg::res_t  head;

  assign cfg_ready = 1'b1;
  assign adv       = in_vld && room;
  assign in_ready  = !in_vld || adv;
  assign push_n    = adv ? step.n : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ready) begin
      in_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_q <= char_in;
      end_q  <= end_mark;
    end
  end

  icc_core #(
    .NAME_BYTES (NAME_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (adv),
    .char_q    (char_q),
    .end_q     (end_q),
    .step      (step)
  );

  icc_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push0     (step.r0),
    .push1     (step.r1),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign char_out  = head.char_out;
  assign has_char  = head.has_char;
  assign name_done = head.name_done;

  a_done_is_bare: assert property (@(posedge clk) disable iff (rst)
    (out_valid && name_done) |-> (!has_char && (char_out == 8'd0)))
    else $error("terminator result carries a character");

  a_stall_only_when_busy: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (in_vld && !room))
    else $error("input stalled with free input register");

endmodule
`default_nettype wire

// ===== sim/identifier_case_converter_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// identifier_case_converter_top_test
// Self-checking bench for the identifier case converter. A short table of
// names covers each style, leading separators, the length cap, a joiner that
// cannot fit, dropped and copied bytes, and the end item. Randomized phases
// then vary style and length cap, send mostly well-formed names mixed with
// noise, and idle both handshake sides. Each result is compared with a
// behavioral model of the conversion in the bench, or a row's fixed value.
// ----------------------------------------------------------------------------
module identifier_case_converter_top_test;

  localparam int NAME_BYTES = 256;
  localparam int ITEM_TARGET = 1050;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 6;
  localparam icc_pkg::res_t TERM_RESULT = icc_pkg::res_t'{8'h00, 1'b0, 1'b1};

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct packed {
    logic           typed;
    icc_pkg::step_t want;
  } note_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] idx;
    logic [7:0] val;
    logic       em;
    note_t      note;
  } row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_index = 8'h00;
  logic [7:0] cfg_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] char_in = 8'h00;
  logic       end_mark = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] char_out;
  logic       has_char;
  logic       name_done;

  // conversion state
  logic [2:0] style_q = icc_pkg::STYLE_SNAKE;
  logic [7:0] max_q = 8'd255;
  int         out_count = 0;
  logic       joiner_due = 1'b0;
  logic       upper_run = 1'b0;
  logic       raise_due = 1'b0;
  logic       fresh_name = 1'b1;

  icc_pkg::res_t due_results[$];
  note_t         sent_notes[$];
  row_t          dir_tbl[$];

  int   mismatch_count = 0;
  int   checked_count = 0;
  int   reg_writes = 0;
  int   sent_items = 0;
  int   cycle_count = 0;
  logic tx_busy = 1'b0;
  logic rx_busy = 1'b0;

  identifier_case_converter_top #(
    .NAME_BYTES(NAME_BYTES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .char_in(char_in),
    .end_mark(end_mark),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .char_out(char_out),
    .has_char(has_char),
    .name_done(name_done)
  );

  always #5 clk = ~clk;

  function automatic logic is_upper(logic [7:0] c);
    return c >= 8'h41 && c <= 8'h5A;
  endfunction

  function automatic logic is_lower(logic [7:0] c);
    return c >= 8'h61 && c <= 8'h7A;
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    return is_upper(c) || is_lower(c) || (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic is_sep(logic [7:0] c);
    return c == icc_pkg::CH_UNDER || c == icc_pkg::CH_DASH || c == icc_pkg::CH_SPACE;
  endfunction

  function automatic logic [7:0] up_case(logic [7:0] c);
    return is_lower(c) ? c - icc_pkg::CASE_DIFF : c;
  endfunction

  function automatic logic [7:0] down_case(logic [7:0] c);
    return is_upper(c) ? c + icc_pkg::CASE_DIFF : c;
  endfunction

  function automatic icc_pkg::step_t with_char(icc_pkg::step_t s, logic [7:0] c);
    if (s.n == 2'd0) s.r0 = icc_pkg::res_t'{c, 1'b1, 1'b0};
    else s.r1 = icc_pkg::res_t'{c, 1'b1, 1'b0};
    s.n = s.n + 2'd1;
    out_count++;
    return s;
  endfunction

  // results of one accepted item; advances the conversion state
  function automatic icc_pkg::step_t convert_byte(logic [7:0] c, logic em);
    icc_pkg::step_t s;
    int             lim;
    logic [7:0]     ch;
    logic [7:0]     jn;
    logic           r;
    s = '0;
    lim = (int'(max_q) < NAME_BYTES - 1) ? int'(max_q) : NAME_BYTES - 1;
    if (em) begin
      out_count = 0;
      joiner_due = 1'b0;
      upper_run = 1'b0;
      raise_due = 1'b0;
      fresh_name = 1'b1;
      s.n = 2'd1;
      s.r0 = TERM_RESULT;
      return s;
    end
    if (c == 8'h00 || out_count >= lim) return s;
    case (style_q)
      icc_pkg::STYLE_SNAKE, icc_pkg::STYLE_KEBAB: begin
        jn = (style_q == icc_pkg::STYLE_SNAKE) ? icc_pkg::CH_UNDER : icc_pkg::CH_DASH;
        if (is_sep(c)) begin
          if (out_count > 0) joiner_due = 1'b1;
          upper_run = 1'b0;
        end else if (is_alnum(c)) begin
          if (is_upper(c)) begin
            if (out_count > 0 && !upper_run) joiner_due = 1'b1;
            ch = down_case(c);
            upper_run = 1'b1;
          end else begin
            ch = c;
            upper_run = 1'b0;
          end
          if (joiner_due) begin
            if (out_count + 2 <= lim) s = with_char(s, jn);
            joiner_due = 1'b0;
          end
          s = with_char(s, ch);
        end
      end
      icc_pkg::STYLE_CAMEL, icc_pkg::STYLE_PASCAL: begin
        if (is_sep(c)) begin
          raise_due = 1'b1;
        end else if (is_alnum(c)) begin
          if (fresh_name) begin
            ch = (style_q == icc_pkg::STYLE_PASCAL) ? up_case(c) : down_case(c);
          end else if (raise_due) ch = up_case(c);
          else ch = c;
          s = with_char(s, ch);
          raise_due = 1'b0;
          fresh_name = 1'b0;
        end
      end
      icc_pkg::STYLE_TITLE: begin
        r = raise_due || fresh_name;
        if (is_sep(c)) begin
          s = with_char(s, icc_pkg::CH_SPACE);
          r = 1'b1;
        end else if (is_alnum(c)) begin
          s = with_char(s, r ? up_case(c) : down_case(c));
          r = 1'b0;
        end else begin
          s = with_char(s, c);
        end
        raise_due = r;
        fresh_name = 1'b0;
      end
      default: s = with_char(s, c);
    endcase
    return s;
  endfunction

  function automatic row_t byte_row(logic [7:0] c, logic em);
    return row_t'{ROW_ITEM, 8'h00, c, em, note_t'(0)};
  endfunction

  function automatic row_t fixed_row(logic [7:0] c, logic em, icc_pkg::step_t want);
    return row_t'{ROW_ITEM, 8'h00, c, em, note_t'{1'b1, want}};
  endfunction

  function automatic row_t reg_row(logic [7:0] idx, logic [7:0] val);
    return row_t'{ROW_REG, idx, val, 1'b0, note_t'(0)};
  endfunction

  function automatic logic [7:0] pick_char();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 8'($urandom_range(8'h61, 8'h7A));
    if (roll < 60) return 8'($urandom_range(8'h41, 8'h5A));
    if (roll < 70) return 8'($urandom_range(8'h30, 8'h39));
    if (roll < 85) begin
      case ($urandom_range(0, 2))
        0: return icc_pkg::CH_UNDER;
        1: return icc_pkg::CH_DASH;
        default: return icc_pkg::CH_SPACE;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_limit(int phase);
    case (phase % 5)
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(1, 3));
      default: return 8'($urandom_range(4, 40));
    endcase
  endfunction

  task automatic send_item(input logic [7:0] c, input logic em, input note_t note);
    int gap;
    gap = tx_busy ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    char_in <= c;
    end_mark <= em;
    sent_notes.push_back(note);
    sent_items++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // hold input until all results are out and the pipeline has emptied
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    icc_pkg::res_t  got;
    icc_pkg::res_t  want;
    icc_pkg::step_t calc;
    note_t          note;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = icc_pkg::res_t'{char_out, has_char, name_done};
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result: none due, got %h/%b/%b", $time,
                   got.char_out, got.has_char, got.name_done);
          mismatch_count++;
        end else begin
          want = due_results.pop_front();
          checked_count++;
          if (got.char_out !== want.char_out) begin
            $display("%0t: char_out expected %h got %h", $time, want.char_out, got.char_out);
            mismatch_count++;
          end
          if (got.has_char !== want.has_char) begin
            $display("%0t: has_char expected %b got %b", $time, want.has_char, got.has_char);
            mismatch_count++;
          end
          if (got.name_done !== want.name_done) begin
            $display("%0t: name_done expected %b got %b", $time, want.name_done,
                     got.name_done);
            mismatch_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == icc_pkg::REG_STYLE) style_q = cfg_data[2:0];
        else if (cfg_index == icc_pkg::REG_MAX_CHARS) max_q = cfg_data;
        reg_writes++;
      end
      if (in_valid && in_ready) begin
        note = sent_notes.pop_front();
        calc = convert_byte(char_in, end_mark);
        if (note.typed) calc = note.want;
        if (calc.n >= 2'd1) due_results.push_back(calc.r0);
        if (calc.n == 2'd2) due_results.push_back(calc.r1);
      end
    end
  end

  initial begin
    int stall;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      stall = rx_busy ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               due_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int   phase;
    int   names;
    int   len;
    row_t row;
    // snake case from reset
    dir_tbl.push_back(fixed_row("A", 1'b0,
                                icc_pkg::step_t'{2'd1, icc_pkg::res_t'{"a", 1'b1, 1'b0},
                                                 icc_pkg::res_t'(0)}));
    dir_tbl.push_back(byte_row("C", 1'b0));
    dir_tbl.push_back(fixed_row(8'hFF, 1'b0, icc_pkg::step_t'(0)));
    dir_tbl.push_back(fixed_row(8'h00, 1'b0, icc_pkg::step_t'(0)));
    dir_tbl.push_back(byte_row("z", 1'b0));
    dir_tbl.push_back(byte_row(" ", 1'b0));
    dir_tbl.push_back(fixed_row(8'hA5, 1'b1,
                                icc_pkg::step_t'{2'd1, TERM_RESULT, icc_pkg::res_t'(0)}));
    dir_tbl.push_back(byte_row("_", 1'b0));
    dir_tbl.push_back(byte_row("X", 1'b0));
    dir_tbl.push_back(byte_row(8'h00, 1'b1));
    // kebab with a cap too short for joiner plus letter
    dir_tbl.push_back(reg_row(icc_pkg::REG_STYLE, 8'(icc_pkg::STYLE_KEBAB)));
    dir_tbl.push_back(reg_row(icc_pkg::REG_MAX_CHARS, 8'd2));
    dir_tbl.push_back(byte_row("a", 1'b0));
    dir_tbl.push_back(byte_row("B", 1'b0));
    dir_tbl.push_back(byte_row("c", 1'b0));
    dir_tbl.push_back(byte_row(8'hFF, 1'b1));
    dir_tbl.push_back(reg_row(icc_pkg::REG_STYLE, 8'(icc_pkg::STYLE_CAMEL)));
    dir_tbl.push_back(reg_row(icc_pkg::REG_MAX_CHARS, 8'd255));
    dir_tbl.push_back(byte_row(" ", 1'b0));
    dir_tbl.push_back(byte_row("H", 1'b0));
    dir_tbl.push_back(byte_row(" ", 1'b0));
    dir_tbl.push_back(byte_row("t", 1'b0));
    dir_tbl.push_back(byte_row(8'h00, 1'b1));
    dir_tbl.push_back(reg_row(icc_pkg::REG_STYLE, 8'(icc_pkg::STYLE_PASCAL)));
    dir_tbl.push_back(byte_row("q", 1'b0));
    dir_tbl.push_back(byte_row(8'h00, 1'b1));
    dir_tbl.push_back(reg_row(icc_pkg::REG_STYLE, 8'(icc_pkg::STYLE_TITLE)));
    dir_tbl.push_back(byte_row("_", 1'b0));
    dir_tbl.push_back(byte_row("x", 1'b0));
    dir_tbl.push_back(byte_row("Y", 1'b0));
    dir_tbl.push_back(byte_row(8'hC8, 1'b0));
    dir_tbl.push_back(byte_row(8'h00, 1'b1));
    dir_tbl.push_back(reg_row(icc_pkg::REG_STYLE, 8'(icc_pkg::STYLE_ORIG)));
    dir_tbl.push_back(byte_row(8'h80, 1'b0));
    dir_tbl.push_back(byte_row(8'h00, 1'b1));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tbl[i]) begin
      row = dir_tbl[i];
      if (row.kind == ROW_REG) begin
        drain_results();
        write_reg(row.idx, row.val);
      end else begin
        send_item(row.val, row.em, row.note);
      end
    end

    phase = 0;
    while (sent_items < ITEM_TARGET) begin
      drain_results();
      write_reg(icc_pkg::REG_STYLE, 8'(phase % 8));
      if (phase % 3 != 2) write_reg(icc_pkg::REG_MAX_CHARS, pick_limit(phase));
      tx_busy = ($urandom_range(0, 3) == 0);
      rx_busy = ($urandom_range(0, 3) == 0);
      names = $urandom_range(3, 8);
      for (int k = 0; k < names; k++) begin
        if ($urandom_range(0, 6) == 0) begin
          repeat ($urandom_range(1, 6))
            send_item(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0, note_t'(0));
        end else begin
          len = $urandom_range(0, 12);
          repeat (len) send_item(pick_char(), 1'b0, note_t'(0));
          send_item(8'($urandom_range(0, 255)), 1'b1, note_t'(0));
        end
        if (k == 1 && (phase == 0 || $urandom_range(0, 4) == 0)) drain_results();
      end
      phase++;
    end

    drain_results();
    $display("Sent %0d items over %0d random phases of all eight style codes;", sent_items,
             phase);
    $display("checked %0d results after %0d register writes.", checked_count, reg_writes);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
